// ----- hw/rtl/nsf_pkg.sv -----
`default_nettype none

package nsf_pkg;

    localparam int unsigned BUFFER_LIMIT = 128;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_STAR = 8'h2A;
    localparam logic [7:0] PREFIX_LEN = 8'd6;
    localparam logic [7:0] MIN_MAX_LENGTH = 8'd8;
    localparam logic [7:0] RESET_MAX_LENGTH = 8'd128;
    localparam logic [7:0] LIMIT_CAP = 8'(BUFFER_LIMIT > 255 ? 255 : BUFFER_LIMIT);

    localparam logic [1:0] TYPE_UNKNOWN = 2'd0;
    localparam logic [1:0] TYPE_GPGGA = 2'd1;
    localparam logic [1:0] TYPE_GNHDT = 2'd2;
    localparam logic [1:0] TYPE_GNZDA = 2'd3;

    typedef struct packed {
        logic [1:0] sentence_type;
        logic       checksum_ok;
        logic       overflow;
        logic [7:0] computed_sum;
        logic [7:0] received_sum;
        logic [7:0] sentence_length;
    } result_t;

    typedef struct packed {
        logic       is_hex;
        logic [3:0] value;
    } hex_digit_t;

    function automatic hex_digit_t hex_decode(input logic [7:0] c);
        hex_digit_t d;
        d.is_hex = 1'b1;
        d.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            d.value = 4'(c - 8'h30);
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            d.value = 4'(c - 8'h37);
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            d.value = 4'(c - 8'h57);
        end
        else
        begin
            d.is_hex = 1'b0;
        end
        return d;
    endfunction

    // Expected character of each known prefix; row 0 is GPGGA, 1 GNHDT, 2 GNZDA.
    function automatic logic [7:0] prefix_char(input logic [1:0] k, input logic [2:0] p);
        logic [7:0] c;
        c = 8'h00;
        unique case ({k, p})
            5'b00_000, 5'b01_000, 5'b10_000: c = "$";
            5'b00_001, 5'b01_001, 5'b10_001: c = "G";
            5'b00_010:                       c = "P";
            5'b01_010, 5'b10_010:            c = "N";
            5'b00_011, 5'b00_100:            c = "G";
            5'b00_101, 5'b10_101:            c = "A";
            5'b01_011:                       c = "H";
            5'b01_100, 5'b10_100:            c = "D";
            5'b01_101:                       c = "T";
            5'b10_011:                       c = "Z";
            default:                         c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/nsf_parser.sv -----
`default_nettype none

module nsf_parser (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_wr_en,
    input  wire logic [7:0]       cfg_wr_data,
    input  wire logic             accept,
    input  wire logic [7:0]       rx_byte,
    output nsf_pkg::result_t      result,
    output logic                  result_valid
);

    logic [7:0] max_length_reg;
    logic       in_sentence_reg, in_sentence_next;
    logic [7:0] position_reg, position_next;
    logic [7:0] running_xor_reg, running_xor_next;
    logic       star_seen_reg, star_seen_next;
    logic [7:0] last_byte_reg, last_byte_next;
    logic [7:0] second_last_byte_reg, second_last_byte_next;
    logic [2:0] prefix_match_reg, prefix_match_next;

    logic [7:0] limit;
    nsf_pkg::hex_digit_t hi_digit;
    nsf_pkg::hex_digit_t lo_digit;
    logic [7:0] recv_sum;
    logic       sum_ok;
    logic [1:0] type_code;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_length_reg <= nsf_pkg::RESET_MAX_LENGTH;
        end
        else if (cfg_wr_en)
        begin
            max_length_reg <= cfg_wr_data;
        end
    end

    always_comb
    begin
        limit = max_length_reg;
        if (limit < nsf_pkg::MIN_MAX_LENGTH)
        begin
            limit = nsf_pkg::MIN_MAX_LENGTH;
        end
        if (limit > nsf_pkg::LIMIT_CAP)
        begin
            limit = nsf_pkg::LIMIT_CAP;
        end
    end

    assign hi_digit = nsf_pkg::hex_decode(second_last_byte_reg);
    assign lo_digit = nsf_pkg::hex_decode(last_byte_reg);
    assign recv_sum = (hi_digit.is_hex && lo_digit.is_hex) ?
                      {hi_digit.value, lo_digit.value} : 8'd0;
    assign sum_ok = hi_digit.is_hex && lo_digit.is_hex && (recv_sum == running_xor_reg);

    // When several prefixes still match, the highest type code wins.
    always_comb
    begin
        type_code = nsf_pkg::TYPE_UNKNOWN;
        if (sum_ok && position_reg >= nsf_pkg::PREFIX_LEN)
        begin
            priority if (prefix_match_reg[2])
            begin
                type_code = nsf_pkg::TYPE_GNZDA;
            end
            else if (prefix_match_reg[1])
            begin
                type_code = nsf_pkg::TYPE_GNHDT;
            end
            else if (prefix_match_reg[0])
            begin
                type_code = nsf_pkg::TYPE_GPGGA;
            end
            else
            begin
                type_code = nsf_pkg::TYPE_UNKNOWN;
            end
        end
    end

    always_comb
    begin
        in_sentence_next = in_sentence_reg;
        position_next = position_reg;
        running_xor_next = running_xor_reg;
        star_seen_next = star_seen_reg;
        last_byte_next = last_byte_reg;
        second_last_byte_next = second_last_byte_reg;
        prefix_match_next = prefix_match_reg;
        result_valid = 1'b0;
        result = '0;

        if (accept)
        begin
            priority if (rx_byte == nsf_pkg::CH_DOLLAR)
            begin
                in_sentence_next = 1'b1;
                position_next = 8'd1;
                running_xor_next = 8'd0;
                star_seen_next = 1'b0;
                prefix_match_next = 3'b111;
                second_last_byte_next = 8'd0;
                last_byte_next = rx_byte;
            end
            else if (!in_sentence_reg)
            begin
                in_sentence_next = 1'b0;
            end
            else if (position_reg >= limit)
            begin
                result_valid = 1'b1;
                result.overflow = 1'b1;
                result.sentence_length = position_reg;
                in_sentence_next = 1'b0;
            end
            else if (rx_byte == nsf_pkg::CH_CR)
            begin
                result_valid = 1'b1;
                result.sentence_type = type_code;
                result.checksum_ok = sum_ok;
                result.computed_sum = running_xor_reg;
                result.received_sum = recv_sum;
                result.sentence_length = position_reg;
                in_sentence_next = 1'b0;
            end
            else
            begin
                if (position_reg < nsf_pkg::PREFIX_LEN)
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        if (nsf_pkg::prefix_char(2'(k), position_reg[2:0]) != rx_byte)
                        begin
                            prefix_match_next[k] = 1'b0;
                        end
                    end
                end
                if (!star_seen_reg)
                begin
                    if (rx_byte == nsf_pkg::CH_STAR)
                    begin
                        star_seen_next = 1'b1;
                    end
                    else
                    begin
                        running_xor_next = running_xor_reg ^ rx_byte;
                    end
                end
                second_last_byte_next = last_byte_reg;
                last_byte_next = rx_byte;
                position_next = position_reg + 8'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_sentence_reg <= 1'b0;
            position_reg <= 8'd0;
            running_xor_reg <= 8'd0;
            star_seen_reg <= 1'b0;
            last_byte_reg <= 8'd0;
            second_last_byte_reg <= 8'd0;
            prefix_match_reg <= 3'b111;
        end
        else
        begin
            in_sentence_reg <= in_sentence_next;
            position_reg <= position_next;
            running_xor_reg <= running_xor_next;
            star_seen_reg <= star_seen_next;
            last_byte_reg <= last_byte_next;
            second_last_byte_reg <= second_last_byte_next;
            prefix_match_reg <= prefix_match_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/nsf_out_reg.sv -----
`default_nettype none

module nsf_out_reg (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire nsf_pkg::result_t  load_data,
    input  wire logic              out_ready,
    output logic                   out_valid,
    output nsf_pkg::result_t       out_data,
    output logic                   in_ready
);

    logic             valid_reg, valid_next;
    nsf_pkg::result_t data_reg;

    // The slot is free when empty or when its transaction completes this cycle.
    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (out_ready)
        begin
            valid_next = 1'b0;
        end
        if (load)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data = data_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/nmea_sentence_framer_top.sv -----
// NMEA sentence framer: takes one received byte per transaction and can accept a byte in
// every clock cycle. A byte is handled in the cycle it is accepted, and its result, if any,
// appears on the output in the next cycle from a single result register. s_tready drops only
// while that register holds a result that m_tready has not yet taken, so the throughput is
// one byte per cycle whenever the output side keeps up. A result is emitted on carriage
// return or when a sentence reaches the length limit (max_length, clamped to 8..128);
// cfg_wr_en writes max_length and should only be used while no result is pending.
`default_nettype none

module nmea_sentence_framer_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [7:0]  cfg_wr_data,   // max_length
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,       // [7:0] rx_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,       // [0] checksum_ok, [8:1] computed_sum,
                                            // [16:9] received_sum, [24:17] sentence_length
    output logic [2:0]       m_tuser        // [1:0] sentence_type, [2] overflow
);

    logic             accept;
    logic             res_valid;
    nsf_pkg::result_t res;
    nsf_pkg::result_t out_res;

    assign accept = s_tvalid && s_tready;

    nsf_parser u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .accept       (accept),
        .rx_byte      (s_tdata),
        .result       (res),
        .result_valid (res_valid)
    );

    nsf_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_valid),
        .load_data (res),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_data  (out_res),
        .in_ready  (s_tready)
    );

    assign m_tdata = {7'd0, out_res.sentence_length, out_res.received_sum,
                      out_res.computed_sum, out_res.checksum_ok};
    assign m_tuser = {out_res.overflow, out_res.sentence_type};

endmodule

`default_nettype wire

// ----- hw/rtl/nsf_checker.sv -----
`default_nettype none

module nsf_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic [2:0]  m_tuser
);

    // A held result must not change until its transaction completes.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Input side stalls only because of a pending result.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // An overflow result carries no type, checksum or sums.
    a_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[2] |-> m_tuser[1:0] == 2'd0 && m_tdata[16:0] == 17'd0)
        else $error("overflow result with payload");

    // A known sentence type needs a good checksum.
    a_type: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1:0] != 2'd0 |-> m_tdata[0] && m_tdata[8:1] == m_tdata[16:9])
        else $error("typed result without matching checksum");

endmodule

bind nmea_sentence_framer_top nsf_checker u_nsf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
